### hdl/omca_pkg.sv
// Shared types, codes and widths for the online mean and covariance accumulator.
package omca_pkg;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // push groups
  localparam logic [2:0] GRP_PRED = 3'd0;
  localparam logic [2:0] GRP_RESP = 3'd1;
  // read groups
  localparam logic [2:0] GRP_PRED_MEAN = 3'd0;
  localparam logic [2:0] GRP_RESP_MEAN = 3'd1;
  localparam logic [2:0] GRP_PRED_COV  = 3'd2;
  localparam logic [2:0] GRP_CROSS_COV = 3'd3;
  localparam logic [2:0] GRP_RESP_VAR  = 3'd4;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX  = 2'd1;
  localparam logic [1:0] STAT_FEW_EVENTS = 2'd2;
  localparam logic [1:0] STAT_BAD_GROUP  = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_COUNT = 1'b1;

  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;

  typedef struct packed {
    logic               action;
    logic [2:0]         group;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] sample_value;
    logic               last_of_event;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] read_value;
    logic [31:0]        event_count;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CALC,
    S_A_DIV,
    S_B_RDA,
    S_B_RDB,
    S_B_MUL,
    S_B_START,
    S_B_DIV,
    S_R_ISSUE,
    S_R_MEAN,
    S_R_CM,
    S_R_DIV,
    S_R_OUT
  } seq_state_t;

endpackage

### hdl/omca_ram.sv
// Generic single-write, single-read RAM with registered read data.
module omca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/omca_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
module omca_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [omca_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [omca_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [omca_pkg::DIV_NUM_W-1:0]  quotient
);

  localparam int NW = omca_pkg::DIV_NUM_W;
  localparam int DW = omca_pkg::DIV_DEN_W;
  localparam int CNTW = $clog2(NW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   num;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den;
  logic [DW+1:0]   diff;
  logic            fits;
  logic [DW-1:0]   rem_next;

  always_comb begin
    diff     = {1'b0, rem, num[NW-1]} - {2'b00, den};
    fits     = !diff[DW+1];
    rem_next = fits ? diff[DW-1:0] : {rem[DW-2:0], num[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= {num[NW-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = num;

endmodule

### hdl/online_mean_covariance_accumulator_top.sv
// Online mean and covariance accumulator: sequencer, datapath and state memories.
//
// Input words arrive on in_valid/in_ready. A push word stores one event element
// (predictor or response); a push marked last_of_event starts the event update,
// during which in_ready is low. The update walks every variable in use for the
// means, then every co-moment in use; all divides go through one shared
// bit-serial divider, which sets the update length. On the first event no divide
// is needed. A read word for a covariance also goes through the divider, and
// every read word yields one result word on out_valid/out_ready.
// The result sits in an output register; the block takes new words while it
// waits. If a second read finishes before the first result is taken, the block
// holds until the output register frees up.
// After reset a clearing pass zeroes the mean and co-moment memories, one entry
// per cycle over the NUM_P*(NUM_P+1)/2 + NUM_P*NUM_Y + NUM_Y entries (72 by default);
// in_ready stays low meanwhile. Configuration writes are taken at any time and
// are clamped to 1..NUM_P and 1..NUM_Y.
module online_mean_covariance_accumulator_top #(
  parameter int NUM_P = 8,
  parameter int NUM_Y = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  omca_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output omca_pkg::out_word_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [omca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [omca_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int NV       = NUM_P + NUM_Y;
  localparam int VAW      = $clog2(NV);
  localparam int TRI      = NUM_P * (NUM_P + 1) / 2;
  localparam int XBASE    = TRI;
  localparam int VBASE    = TRI + NUM_P * NUM_Y;
  localparam int CM_DEPTH = VBASE + NUM_Y;
  localparam int CAW      = $clog2(CM_DEPTH);
  localparam int MX       = (NUM_P > NUM_Y) ? NUM_P : NUM_Y;
  localparam int CW       = $clog2(MX + 1);
  localparam int MW       = 48;
  localparam int DLW      = 34;

  typedef enum logic [1:0] {K_TRI, K_CROSS, K_VAR} pass_t;

  function automatic logic [CAW-1:0] tri_addr(input int i, input int j);
    return CAW'(i * NUM_P - (i * (i - 1)) / 2 + j - i);
  endfunction

  omca_pkg::seq_state_t state, state_next;

  logic [CW-1:0]  pcount, ycount;
  logic [31:0]    events_seen;
  logic [CAW-1:0] clr_addr;
  logic [VAW-1:0] a_idx;
  pass_t          kind, kind_next;
  logic [CW-1:0]  bi, bj, bi_next, bj_next;
  logic           b_done;

  logic [MW-1:0]  mean_r;
  logic           mean_neg;
  logic [DLW-1:0] da_r;
  logic [63:0]    prod_r;
  logic           prod_neg;
  logic [63:0]    cm_r;
  logic           cov_neg;
  logic [2:0]     r_group, r_row, r_col;
  logic [63:0]    res_value;
  logic [1:0]     res_status;

  // memories
  logic           buf_we;
  logic [VAW-1:0] buf_waddr;
  logic [31:0]    buf_rdata;
  logic           mean_we;
  logic [VAW-1:0] mean_waddr, mean_raddr;
  logic [MW-1:0]  mean_wdata, mean_rdata;
  logic           dlt_we;
  logic [VAW-1:0] dlt_raddr;
  logic [DLW-1:0] dlt_wdata, dlt_rdata;
  logic           cm_we;
  logic [CAW-1:0] cm_waddr, cm_raddr, cm_addr_b, rd_cm_addr;
  logic [63:0]    cm_wdata, cm_rdata;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;

  // datapath
  logic [MW-1:0]  up48;
  logic [MW:0]    delta, dmag;
  logic           dneg;
  logic [MW+1:0]  dround;
  logic           n_first;
  logic [31:0]    half_n, dm1;
  logic           a_in_use, a_last;
  logic [MW-1:0]  mean_new;
  logic [65:0]    prod_full;
  logic [63:0]    term;
  logic [65:0]    sum66;
  logic [63:0]    sat_sum;
  logic [63:0]    cmag;
  logic [MW:0]    msum;
  logic [63:0]    mean_read;
  logic [VAW-1:0] ia_addr, ib_addr, rd_mean_addr;
  logic [1:0]     rd_status;
  logic           rd_is_mean, rd_phase;
  logic [2:0]     r_lo, r_hi;
  logic           push_pred, push_resp;
  logic [4:0]     pc_clamp, yc_clamp;

  omca_ram #(.WIDTH(32), .DEPTH(NV)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(in_data.sample_value),
    .raddr(a_idx), .rdata(buf_rdata)
  );

  omca_ram #(.WIDTH(MW), .DEPTH(NV)) u_mean (
    .clk(clk), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
    .raddr(mean_raddr), .rdata(mean_rdata)
  );

  omca_ram #(.WIDTH(DLW), .DEPTH(NV)) u_dlt (
    .clk(clk), .we(dlt_we), .waddr(a_idx), .wdata(dlt_wdata),
    .raddr(dlt_raddr), .rdata(dlt_rdata)
  );

  omca_ram #(.WIDTH(64), .DEPTH(CM_DEPTH)) u_cm (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );

  omca_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q)
  );

  // ---------------- arithmetic ----------------
  always_comb begin
    up48     = {buf_rdata, 16'h0000};
    delta    = {up48[MW-1], up48} - {mean_rdata[MW-1], mean_rdata};
    dneg     = delta[MW];
    dmag     = dneg ? ((MW+1)'(0) - delta) : delta;
    dround   = {1'b0, dmag} + (MW+2)'(32768);
    dlt_wdata = {dneg, dround[MW:16]};
    n_first  = (events_seen == 32'd1);
    half_n   = {1'b0, events_seen[31:1]};
    dm1      = events_seen - 32'd1;
    mean_new = mean_r + (mean_neg ? (MW'(0) - div_q[MW-1:0]) : div_q[MW-1:0]);

    prod_full = da_r[32:0] * dlt_rdata[32:0];
    term      = prod_r - div_q;
    sum66     = {{2{cm_r[63]}}, cm_r} + (prod_neg ? (66'd0 - {2'b00, term}) : {2'b00, term});
    if (sum66[65:63] == 3'b000 || sum66[65:63] == 3'b111) begin
      sat_sum = sum66[63:0];
    end else if (sum66[65]) begin
      sat_sum = {1'b1, 63'd0};
    end else begin
      sat_sum = {1'b0, {63{1'b1}}};
    end

    cmag      = cm_rdata[63] ? (64'd0 - cm_rdata) : cm_rdata;
    msum      = {mean_rdata[MW-1], mean_rdata} + (MW+1)'(32768);
    mean_read = {{31{msum[MW]}}, msum[MW:16]};

    a_in_use = (int'(a_idx) < NUM_P) ? (int'(a_idx) < int'(pcount))
                                     : ((int'(a_idx) - NUM_P) < int'(ycount));
    a_last   = (a_idx == VAW'(NV - 1));
  end

  // ---------------- co-moment walk ----------------
  always_comb begin
    kind_next = kind;
    bi_next   = bi;
    bj_next   = bj;
    b_done    = 1'b0;
    unique case (kind)
      K_TRI: begin
        if (int'(bj) + 1 < int'(pcount)) begin
          bj_next = bj + 1'b1;
        end else begin
          kind_next = K_CROSS;
          bj_next   = '0;
        end
      end
      K_CROSS: begin
        if (int'(bj) + 1 < int'(ycount)) begin
          bj_next = bj + 1'b1;
        end else if (int'(bi) + 1 < int'(pcount)) begin
          kind_next = K_TRI;
          bi_next   = bi + 1'b1;
          bj_next   = bi + 1'b1;
        end else begin
          kind_next = K_VAR;
          bi_next   = '0;
          bj_next   = '0;
        end
      end
      K_VAR: begin
        if (int'(bj) + 1 < int'(ycount)) begin
          bj_next = bj + 1'b1;
        end else begin
          b_done = 1'b1;
        end
      end
      default: begin
        b_done = 1'b1;
      end
    endcase

    unique case (kind)
      K_TRI: begin
        ia_addr   = VAW'(bi);
        ib_addr   = VAW'(bj);
        cm_addr_b = tri_addr(int'(bi), int'(bj));
      end
      K_CROSS: begin
        ia_addr   = VAW'(bi);
        ib_addr   = VAW'(NUM_P + int'(bj));
        cm_addr_b = CAW'(XBASE + int'(bi) * NUM_Y + int'(bj));
      end
      default: begin
        ia_addr   = VAW'(NUM_P + int'(bj));
        ib_addr   = VAW'(NUM_P + int'(bj));
        cm_addr_b = CAW'(VBASE + int'(bj));
      end
    endcase
  end

  // ---------------- read decode ----------------
  always_comb begin
    r_lo = (r_row < r_col) ? r_row : r_col;
    r_hi = (r_row < r_col) ? r_col : r_row;
    rd_is_mean   = (r_group == omca_pkg::GRP_PRED_MEAN) || (r_group == omca_pkg::GRP_RESP_MEAN);
    rd_mean_addr = (r_group == omca_pkg::GRP_PRED_MEAN) ? VAW'(r_row) : VAW'(NUM_P + int'(r_row));
    rd_status    = omca_pkg::STAT_OK;
    rd_cm_addr   = CAW'(VBASE + int'(r_row));
    priority if (r_group > omca_pkg::GRP_RESP_VAR) begin
      rd_status = omca_pkg::STAT_BAD_GROUP;
    end else if (r_group == omca_pkg::GRP_PRED_MEAN) begin
      if (int'(r_row) >= int'(pcount)) rd_status = omca_pkg::STAT_BAD_INDEX;
      else if (events_seen == 32'd0)   rd_status = omca_pkg::STAT_FEW_EVENTS;
    end else if (r_group == omca_pkg::GRP_RESP_MEAN) begin
      if (int'(r_row) >= int'(ycount)) rd_status = omca_pkg::STAT_BAD_INDEX;
      else if (events_seen == 32'd0)   rd_status = omca_pkg::STAT_FEW_EVENTS;
    end else begin
      if (r_group == omca_pkg::GRP_PRED_COV) begin
        rd_cm_addr = tri_addr(int'(r_lo), int'(r_hi));
        if (int'(r_hi) >= int'(pcount)) rd_status = omca_pkg::STAT_BAD_INDEX;
      end else if (r_group == omca_pkg::GRP_CROSS_COV) begin
        rd_cm_addr = CAW'(XBASE + int'(r_row) * NUM_Y + int'(r_col));
        if (int'(r_row) >= int'(pcount) || int'(r_col) >= int'(ycount)) begin
          rd_status = omca_pkg::STAT_BAD_INDEX;
        end
      end else begin
        if (int'(r_row) >= int'(ycount)) rd_status = omca_pkg::STAT_BAD_INDEX;
      end
      if (rd_status == omca_pkg::STAT_OK && events_seen < 32'd2) begin
        rd_status = omca_pkg::STAT_FEW_EVENTS;
      end
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= omca_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    push_pred    = (in_data.group == omca_pkg::GRP_PRED) && (int'(in_data.row_index) < int'(pcount));
    push_resp    = (in_data.group == omca_pkg::GRP_RESP) && (int'(in_data.row_index) < int'(ycount));
    buf_we       = 1'b0;
    buf_waddr    = push_pred ? VAW'(in_data.row_index) : VAW'(NUM_P + int'(in_data.row_index));
    rd_phase     = (state == omca_pkg::S_R_ISSUE) || (state == omca_pkg::S_R_MEAN) ||
                   (state == omca_pkg::S_R_CM);
    mean_we      = 1'b0;
    mean_waddr   = a_idx;
    mean_wdata   = mean_new;
    mean_raddr   = rd_phase ? rd_mean_addr : a_idx;
    dlt_we       = 1'b0;
    dlt_raddr    = (state == omca_pkg::S_B_RDA) ? ia_addr : ib_addr;
    cm_we        = 1'b0;
    cm_waddr     = cm_addr_b;
    cm_wdata     = sat_sum;
    cm_raddr     = rd_phase ? rd_cm_addr : cm_addr_b;
    div_start    = 1'b0;
    div_dividend = {15'd0, dmag} + {32'd0, half_n};
    div_divisor  = events_seen;

    unique case (state)
      omca_pkg::S_CLEAR: begin
        cm_we      = 1'b1;
        cm_waddr   = clr_addr;
        cm_wdata   = '0;
        mean_we    = (int'(clr_addr) < NV);
        mean_waddr = VAW'(clr_addr);
        mean_wdata = '0;
        if (clr_addr == CAW'(CM_DEPTH - 1)) state_next = omca_pkg::S_IDLE;
      end
      omca_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.action == omca_pkg::ACT_PUSH) begin
            buf_we = push_pred || push_resp;
            if (in_data.last_of_event) state_next = omca_pkg::S_A_RD;
          end else begin
            state_next = omca_pkg::S_R_ISSUE;
          end
        end
      end
      omca_pkg::S_A_RD: begin
        if (a_in_use)    state_next = omca_pkg::S_A_CALC;
        else if (a_last) state_next = omca_pkg::S_B_RDA;
      end
      omca_pkg::S_A_CALC: begin
        dlt_we = 1'b1;
        if (n_first) begin
          mean_we    = 1'b1;
          mean_wdata = up48;
          state_next = a_last ? omca_pkg::S_B_RDA : omca_pkg::S_A_RD;
        end else begin
          div_start  = 1'b1;
          state_next = omca_pkg::S_A_DIV;
        end
      end
      omca_pkg::S_A_DIV: begin
        if (div_done) begin
          mean_we    = 1'b1;
          state_next = a_last ? omca_pkg::S_B_RDA : omca_pkg::S_A_RD;
        end
      end
      omca_pkg::S_B_RDA: state_next = omca_pkg::S_B_RDB;
      omca_pkg::S_B_RDB: state_next = omca_pkg::S_B_MUL;
      omca_pkg::S_B_MUL: begin
        if (n_first) begin
          cm_we      = 1'b1;
          cm_wdata   = '0;
          state_next = b_done ? omca_pkg::S_IDLE : omca_pkg::S_B_RDA;
        end else begin
          state_next = omca_pkg::S_B_START;
        end
      end
      omca_pkg::S_B_START: begin
        div_start    = 1'b1;
        div_dividend = prod_r + {32'd0, half_n};
        state_next   = omca_pkg::S_B_DIV;
      end
      omca_pkg::S_B_DIV: begin
        if (div_done) begin
          cm_we      = 1'b1;
          state_next = b_done ? omca_pkg::S_IDLE : omca_pkg::S_B_RDA;
        end
      end
      omca_pkg::S_R_ISSUE: begin
        if (rd_status != omca_pkg::STAT_OK) state_next = omca_pkg::S_R_OUT;
        else if (rd_is_mean)                state_next = omca_pkg::S_R_MEAN;
        else                                state_next = omca_pkg::S_R_CM;
      end
      omca_pkg::S_R_MEAN: state_next = omca_pkg::S_R_OUT;
      omca_pkg::S_R_CM: begin
        div_start    = 1'b1;
        div_dividend = cmag + {33'd0, dm1[31:1]};
        div_divisor  = dm1;
        state_next   = omca_pkg::S_R_DIV;
      end
      omca_pkg::S_R_DIV: begin
        if (div_done) state_next = omca_pkg::S_R_OUT;
      end
      omca_pkg::S_R_OUT: begin
        if (!out_valid || out_ready) state_next = omca_pkg::S_IDLE;
      end
      default: state_next = omca_pkg::S_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      a_idx       <= '0;
      kind        <= K_TRI;
      bi          <= '0;
      bj          <= '0;
      events_seen <= '0;
    end else begin
      if (state == omca_pkg::S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == omca_pkg::S_IDLE && in_valid && in_data.action == omca_pkg::ACT_PUSH &&
          in_data.last_of_event) begin
        a_idx <= '0;
        if (events_seen != 32'hFFFF_FFFF) events_seen <= events_seen + 32'd1;
      end
      if ((state == omca_pkg::S_A_RD && !a_in_use && !a_last) ||
          (state == omca_pkg::S_A_CALC && n_first && !a_last) ||
          (state == omca_pkg::S_A_DIV && div_done && !a_last)) begin
        a_idx <= a_idx + 1'b1;
      end
      if (state_next == omca_pkg::S_B_RDA &&
          (state == omca_pkg::S_A_RD || state == omca_pkg::S_A_CALC ||
           state == omca_pkg::S_A_DIV)) begin
        kind <= K_TRI;
        bi   <= '0;
        bj   <= '0;
      end else if (state_next == omca_pkg::S_B_RDA) begin
        kind <= kind_next;
        bi   <= bi_next;
        bj   <= bj_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= CW'(NUM_P);
      ycount <= CW'(NUM_Y);
    end else if (cfg_we) begin
      unique case (cfg_index)
        omca_pkg::CFG_PRED_COUNT: pcount <= CW'(pc_clamp);
        omca_pkg::CFG_RESP_COUNT: ycount <= CW'(yc_clamp);
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_clamp = {1'b0, cfg_data};
    if (pc_clamp > 5'(NUM_P)) pc_clamp = 5'(NUM_P);
    if (pc_clamp == 5'd0)     pc_clamp = 5'd1;
    yc_clamp = {2'b00, cfg_data[2:0]};
    if (yc_clamp > 5'(NUM_Y)) yc_clamp = 5'(NUM_Y);
    if (yc_clamp == 5'd0)     yc_clamp = 5'd1;
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (state == omca_pkg::S_A_CALC) begin
      mean_r   <= mean_rdata;
      mean_neg <= dneg;
    end
    if (state == omca_pkg::S_B_RDB) da_r <= dlt_rdata;
    if (state == omca_pkg::S_B_MUL) begin
      prod_r   <= prod_full[63:0];
      prod_neg <= da_r[DLW-1] ^ dlt_rdata[DLW-1];
      cm_r     <= cm_rdata;
    end
    if (state == omca_pkg::S_IDLE) begin
      r_group <= in_data.group;
      r_row   <= in_data.row_index;
      r_col   <= in_data.col_index;
    end
    if (state == omca_pkg::S_R_ISSUE) begin
      res_status <= rd_status;
      res_value  <= '0;
    end
    if (state == omca_pkg::S_R_MEAN) res_value <= mean_read;
    if (state == omca_pkg::S_R_CM)   cov_neg   <= cm_rdata[63];
    if (state == omca_pkg::S_R_DIV && div_done) begin
      res_value <= cov_neg ? (64'd0 - div_q) : div_q;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == omca_pkg::S_R_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == omca_pkg::S_R_OUT && (!out_valid || out_ready)) begin
      out_data.read_value  <= res_value;
      out_data.event_count <= events_seen;
      out_data.status      <= res_status;
    end
  end

  // ---------------- assertions ----------------
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == omca_pkg::S_A_DIV || state == omca_pkg::S_B_DIV ||
                  state == omca_pkg::S_R_DIV))
    else $error("divider finished while nobody waited");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> events_seen >= $past(events_seen))
    else $error("event count went down");

  a_bad_status_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != omca_pkg::STAT_OK) |-> out_data.read_value == 64'sd0)
    else $error("nonzero value with error status");

  a_word_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == omca_pkg::S_R_OUT)
    else $error("result word without a finished read");

endmodule

### tb/tb.sv
// Testbench for online_mean_covariance_accumulator_top: directed table, then random events and reads.
module tb;
  import omca_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  online_mean_covariance_accumulator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // statistics shadow
  logic signed [31:0] ev_buf [12];
  logic signed [63:0] mean_p [8];
  logic signed [63:0] mean_y [4];
  logic signed [63:0] cm_pp [36];
  logic signed [63:0] cm_py [32];
  logic signed [63:0] var_y [4];
  logic [31:0] n_events;
  int unsigned n_pred, n_resp;

  out_word_t pending_reads [$];
  int  mismatches = 0;
  int  tx_idle = 22, rx_idle = 79;
  int  hold_left = 0;
  int  stall_cnt = 0;

  function automatic logic [63:0] mag64(logic signed [63:0] a);
    return a < 0 ? 64'd0 - a : a;
  endfunction

  // nearest, ties away from zero
  function automatic logic signed [63:0] div_near(logic signed [63:0] a, logic [63:0] d);
    logic [63:0] q;
    q = (mag64(a) + d / 2) / d;
    return a < 0 ? 64'd0 - q : q;
  endfunction

  function automatic logic signed [63:0] comoment_add(logic signed [63:0] c,
      logic signed [63:0] da, logic signed [63:0] db, logic [31:0] n);
    logic [63:0] p, m, room;
    logic neg;
    p = mag64(da) * mag64(db);
    m = p - (p + 64'(n / 2)) / 64'(n);
    neg = (da < 0) != (db < 0);
    if (!neg) begin
      room = 64'h7FFF_FFFF_FFFF_FFFF - c;
      return (m > room) ? 64'h7FFF_FFFF_FFFF_FFFF : c + m;
    end
    room = c - 64'h8000_0000_0000_0000;
    return (m > room) ? 64'h8000_0000_0000_0000 : c - m;
  endfunction

  function automatic int tri_at(int i, int j);
    return i * 8 - (i * (i - 1)) / 2 + (j - i);
  endfunction

  function automatic void fold_event();
    logic signed [63:0] dp [8];
    logic signed [63:0] dy [4];
    logic signed [63:0] u;
    logic [31:0] n;
    if (n_events != 32'hFFFF_FFFF) n_events++;
    n = n_events;
    for (int i = 0; i < n_pred; i++) begin
      u = 64'(ev_buf[i]) * 65536;
      dp[i] = u - mean_p[i];
      mean_p[i] = (n <= 1) ? u : mean_p[i] + div_near(dp[i], n);
      dp[i] = div_near(dp[i], 65536);
    end
    for (int i = 0; i < n_resp; i++) begin
      u = 64'(ev_buf[8 + i]) * 65536;
      dy[i] = u - mean_y[i];
      mean_y[i] = (n <= 1) ? u : mean_y[i] + div_near(dy[i], n);
      dy[i] = div_near(dy[i], 65536);
    end
    for (int i = 0; i < n_pred; i++) begin
      for (int j = i; j < n_pred; j++)
        cm_pp[tri_at(i, j)] = (n <= 1) ? 64'sd0 : comoment_add(cm_pp[tri_at(i, j)], dp[i], dp[j], n);
      for (int j = 0; j < n_resp; j++)
        cm_py[i * 4 + j] = (n <= 1) ? 64'sd0 : comoment_add(cm_py[i * 4 + j], dp[i], dy[j], n);
    end
    for (int j = 0; j < n_resp; j++)
      var_y[j] = (n <= 1) ? 64'sd0 : comoment_add(var_y[j], dy[j], dy[j], n);
  endfunction

  // returns 1 when the word yields a result
  function automatic bit apply_word(in_word_t w, output out_word_t r);
    logic signed [63:0] c;
    int unsigned a, b;
    r = '0;
    c = 0;
    if (w.action == ACT_PUSH) begin
      if (w.group == GRP_PRED && w.row_index < n_pred) ev_buf[w.row_index] = w.sample_value;
      else if (w.group == GRP_RESP && w.row_index < n_resp) ev_buf[8 + w.row_index] = w.sample_value;
      if (w.last_of_event) fold_event();
      return 0;
    end
    r.event_count = n_events;
    r.status = STAT_OK;
    if (w.group > GRP_RESP_VAR) r.status = STAT_BAD_GROUP;
    else if (w.group == GRP_PRED_MEAN || w.group == GRP_RESP_MEAN) begin
      if (w.row_index >= (w.group == GRP_PRED_MEAN ? n_pred : n_resp)) r.status = STAT_BAD_INDEX;
      else if (n_events < 1) r.status = STAT_FEW_EVENTS;
      else begin
        c = (w.group == GRP_PRED_MEAN) ? mean_p[w.row_index] : mean_y[w.row_index];
        r.read_value = (c + 64'sh8000) >>> 16;
      end
    end else begin
      if (w.group == GRP_PRED_COV) begin
        a = w.row_index < w.col_index ? w.row_index : w.col_index;
        b = w.row_index < w.col_index ? w.col_index : w.row_index;
        if (b >= n_pred) r.status = STAT_BAD_INDEX;
        else c = cm_pp[tri_at(a, b)];
      end else if (w.group == GRP_CROSS_COV) begin
        if (w.row_index >= n_pred || w.col_index >= n_resp) r.status = STAT_BAD_INDEX;
        else c = cm_py[w.row_index * 4 + w.col_index];
      end else begin
        if (w.row_index >= n_resp) r.status = STAT_BAD_INDEX;
        else c = var_y[w.row_index];
      end
      if (r.status == STAT_OK && n_events < 2) r.status = STAT_FEW_EVENTS;
      if (r.status == STAT_OK) r.read_value = div_near(c, 64'(n_events) - 1);
    end
    return 1;
  endfunction

  function automatic in_word_t mk(logic act, logic [2:0] grp, logic [2:0] row, logic [2:0] col,
                                  logic [31:0] val, logic last);
    in_word_t w;
    w.action = act; w.group = grp; w.row_index = row; w.col_index = col;
    w.sample_value = val; w.last_of_event = last;
    return w;
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom % 8)
      0: case ($urandom % 4)
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // accepted-word predictor hook; typed expectation overrides when given
  task automatic send(in_word_t w, bit typed = 0, out_word_t typed_res = '0);
    out_word_t r;
    while ($urandom % 100 < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (apply_word(w, r)) pending_reads.push_back(typed ? typed_res : r);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PRED_COUNT) n_pred = (val & 4'hF) < 1 ? 1 : ((val & 4'hF) > 8 ? 8 : val & 4'hF);
    else n_resp = (val & 3'h7) < 1 ? 1 : ((val & 3'h7) > 4 ? 4 : val & 3'h7);
  endtask

  // wait for all results, then for the update engine to drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_event(bit broken);
    int order [12];
    int cnt, k, t, stop;
    cnt = 0;
    for (int i = 0; i < n_pred; i++) order[cnt++] = i;
    for (int i = 0; i < n_resp; i++) order[cnt++] = 8 + i;
    for (int i = cnt - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = order[i]; order[i] = order[k]; order[k] = t;
    end
    stop = broken ? $urandom_range(1, cnt) : cnt;
    for (int i = 0; i < stop; i++)
      send(mk(ACT_PUSH, order[i] >= 8 ? GRP_RESP : GRP_PRED, 3'(order[i] % 8), 3'($urandom),
              pick_sample(), i == stop - 1));
  endtask

  task automatic random_phase(int items);
    int sent, r;
    logic [2:0] grp, row, col;
    sent = 0;
    while (sent < items) begin
      r = $urandom % 100;
      if (r < 50) begin
        send_event(0);
        sent += n_pred + n_resp;
      end else if (r < 88) begin
        grp = ($urandom % 10 == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
        row = ($urandom % 6 == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
        col = ($urandom % 6 == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
        send(mk(ACT_READ, grp, row, col, $urandom, 1'($urandom)));
        sent++;
      end else if (r < 94) begin
        send_event(1);
        sent++;
      end else begin
        // push with a bad group or a row index of 4 to 7, dropped when out of range
        send(mk(ACT_PUSH, ($urandom % 2) ? 3'($urandom_range(2, 7)) : 3'($urandom_range(0, 1)),
                3'($urandom_range(4, 7)), 3'($urandom), $urandom, ($urandom % 4) == 0));
      end
    end
  endtask

  // receiver: random stalls plus a long hold when requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom % 100) >= rx_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        if (mismatches < 10) $display("unexpected result word %p", out_data);
        mismatches++;
      end else begin
        if (out_data.read_value !== pending_reads[0].read_value ||
            out_data.event_count !== pending_reads[0].event_count ||
            out_data.status !== pending_reads[0].status) begin
          if (mismatches < 10)
            $display("result mismatch: expected %p got %p", pending_reads[0], out_data);
          mismatches++;
        end
        void'(pending_reads.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt == WATCHDOG_LIMIT) begin
      $display("FAIL online_mean_covariance_accumulator_top");
      $finish;
    end
  end

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    logic [3:0]  pred_set [6] = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd1, 4'd5};
    logic [3:0]  resp_set [6] = '{4'd7, 4'd0, 4'd2, 4'd1, 4'd4, 4'd3};
    logic [31:0] p_vals [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
                                32'h0001_0000, 32'hFFFE_8000, 32'h5555_AAAA, 32'hAAAA_5555};
    logic [31:0] y_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_0000};

    n_pred = 8; n_resp = 4; n_events = 0;
    foreach (mean_p[i]) mean_p[i] = 0;
    foreach (mean_y[i]) mean_y[i] = 0;
    foreach (cm_pp[i]) cm_pp[i] = 0;
    foreach (cm_py[i]) cm_py[i] = 0;
    foreach (var_y[i]) var_y[i] = 0;
    foreach (ev_buf[i]) ev_buf[i] = 0;

    rows.push_back('{mk(ACT_READ, GRP_PRED_MEAN, 0, 0, 0, 0), 1, '{0, 0, STAT_FEW_EVENTS}});
    rows.push_back('{mk(ACT_READ, 3'd5, 0, 0, 0, 0), 1, '{0, 0, STAT_BAD_GROUP}});
    rows.push_back('{mk(ACT_READ, 3'd7, 7, 7, 0, 1), 1, '{0, 0, STAT_BAD_GROUP}});
    rows.push_back('{mk(ACT_READ, GRP_PRED_COV, 0, 0, 0, 0), 1, '{0, 0, STAT_FEW_EVENTS}});
    rows.push_back('{mk(ACT_READ, GRP_RESP_MEAN, 7, 0, 0, 0), 1, '{0, 0, STAT_BAD_INDEX}});
    for (int i = 0; i < 8; i++)
      rows.push_back('{mk(ACT_PUSH, GRP_PRED, 3'(i), 0, p_vals[i], 0), 0, '0});
    for (int i = 0; i < 4; i++)
      rows.push_back('{mk(ACT_PUSH, GRP_RESP, 3'(i), 0, y_vals[i], i == 3), 0, '0});
    rows.push_back('{mk(ACT_READ, GRP_PRED_MEAN, 0, 0, 0, 0), 1, '{64'sh7FFF_FFFF, 1, STAT_OK}});
    rows.push_back('{mk(ACT_READ, GRP_PRED_MEAN, 1, 0, 0, 0), 1,
                     '{-64'sh8000_0000, 1, STAT_OK}});
    rows.push_back('{mk(ACT_READ, GRP_RESP_VAR, 0, 0, 0, 0), 1, '{0, 1, STAT_FEW_EVENTS}});
    // dropped push whose last mark still folds the event
    rows.push_back('{mk(ACT_PUSH, 3'd3, 0, 0, 32'h1234_5678, 0), 0, '0});
    rows.push_back('{mk(ACT_PUSH, GRP_PRED, 0, 0, 32'h8000_0000, 0), 0, '0});
    rows.push_back('{mk(ACT_PUSH, GRP_RESP, 6, 0, 32'h7FFF_FFFF, 1), 0, '0});
    rows.push_back('{mk(ACT_READ, GRP_PRED_COV, 5, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_READ, GRP_CROSS_COV, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_READ, GRP_RESP_VAR, 3, 0, 0, 0), 0, '0});
    rows.push_back('{mk(ACT_READ, GRP_CROSS_COV, 0, 5, 0, 0), 1, '{0, 2, STAT_BAD_INDEX}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(CFG_PRED_COUNT, pred_set[ph]);
      cfg_write(CFG_RESP_COUNT, resp_set[ph]);
      tx_idle = (ph / 2 == 0) ? 22 : (ph / 2 == 1) ? 79 : 0;
      rx_idle = (ph / 2 == 0) ? 79 : (ph / 2 == 1) ? 22 : 0;
      if (ph == 4) hold_left = 600;
      random_phase(305);
    end

    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("PASS online_mean_covariance_accumulator_top");
    else
      $display("FAIL online_mean_covariance_accumulator_top");
    $finish;
  end

endmodule
